// File: rtl/ptl_pkg.sv
// Shared types and constants for the pedestrian traffic light controller.
`default_nettype none

package ptl_pkg;

	typedef enum logic [4:0] {
		PH_RED    = 5'b00001,
		PH_BEEP   = 5'b00010,
		PH_GREEN  = 5'b00100,
		PH_HOLD   = 5'b01000,
		PH_YELLOW = 5'b10000
	} phase_t;

	localparam logic [2:0] PHASE_CODE_RED    = 3'd0;
	localparam logic [2:0] PHASE_CODE_BEEP   = 3'd1;
	localparam logic [2:0] PHASE_CODE_GREEN  = 3'd2;
	localparam logic [2:0] PHASE_CODE_HOLD   = 3'd3;
	localparam logic [2:0] PHASE_CODE_YELLOW = 3'd4;

	localparam logic [2:0] REG_RED_LONG     = 3'd0;
	localparam logic [2:0] REG_RED_SHORT    = 3'd1;
	localparam logic [2:0] REG_GREEN_MAX    = 3'd2;
	localparam logic [2:0] REG_EARLY_WINDOW = 3'd3;
	localparam logic [2:0] REG_HOLD         = 3'd4;
	localparam logic [2:0] REG_YELLOW       = 3'd5;
	localparam logic [2:0] REG_BEEP_ON      = 3'd6;
	localparam logic [2:0] REG_BEEP_PERIOD  = 3'd7;

	localparam logic [11:0] TIMER_MAX = 12'hFFF;

	typedef struct packed {
		logic [11:0] red_long_ticks;
		logic [11:0] red_short_ticks;
		logic [11:0] green_max_ticks;
		logic [11:0] early_window_ticks;
		logic [11:0] hold_ticks;
		logic [11:0] yellow_ticks;
		logic [7:0]  beep_on_ticks;
		logic [7:0]  beep_period_ticks;
	} cfg_t;

	typedef struct packed {
		logic       car_red;
		logic       car_yellow;
		logic       car_green;
		logic       walk_red;
		logic       walk_green;
		logic       tone_on;
		logic [2:0] phase;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/pedestrian_traffic_light_controller.sv
// Latency: a tick beat accepted at one edge shows its lamp result from the next cycle on.
// Throughput: one beat per cycle while out_ready is high; the result register refills in the cycle it is taken.
// The phase sequencer updates its counters once per accepted beat, with no iteration.
// Reset (arst_n low, asynchronous) selects the red phase, clears all timers and
// restores every configuration register to its default value.
`default_nettype none

module pedestrian_traffic_light_controller
	import ptl_pkg::*;
#(
	parameter int BEEP_COUNT     = 4,
	parameter int CHECK_INTERVAL = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [11:0] cfg_data,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        button_pressed,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic        car_red,
	output      logic        car_yellow,
	output      logic        car_green,
	output      logic        walk_red,
	output      logic        walk_green,
	output      logic        tone_on,
	output      logic [2:0]  phase
);

	cfg_t    cfg_q;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_long_ticks     <= 12'd800;
			cfg_q.red_short_ticks    <= 12'd200;
			cfg_q.green_max_ticks    <= 12'd800;
			cfg_q.early_window_ticks <= 12'd700;
			cfg_q.hold_ticks         <= 12'd101;
			cfg_q.yellow_ticks       <= 12'd60;
			cfg_q.beep_on_ticks      <= 8'd10;
			cfg_q.beep_period_ticks  <= 8'd15;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RED_LONG:     cfg_q.red_long_ticks     <= cfg_data;
				REG_RED_SHORT:    cfg_q.red_short_ticks    <= cfg_data;
				REG_GREEN_MAX:    cfg_q.green_max_ticks    <= cfg_data;
				REG_EARLY_WINDOW: cfg_q.early_window_ticks <= cfg_data;
				REG_HOLD:         cfg_q.hold_ticks         <= cfg_data;
				REG_YELLOW:       cfg_q.yellow_ticks       <= cfg_data;
				REG_BEEP_ON:      cfg_q.beep_on_ticks      <= cfg_data[7:0];
				REG_BEEP_PERIOD:  cfg_q.beep_period_ticks  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	ptl_seq #(
		.BEEP_COUNT     (BEEP_COUNT),
		.CHECK_INTERVAL (CHECK_INTERVAL)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (accept),
		.button_pressed (button_pressed),
		.cfg            (cfg_q),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign car_red    = res_q.car_red;
	assign car_yellow = res_q.car_yellow;
	assign car_green  = res_q.car_green;
	assign walk_red   = res_q.walk_red;
	assign walk_green = res_q.walk_green;
	assign tone_on    = res_q.tone_on;
	assign phase      = res_q.phase;

endmodule

`default_nettype wire

// File: rtl/ptl_seq.sv
// Phase sequencer: state registers, lamp decode and next-state logic per tick.
`default_nettype none

module ptl_seq
	import ptl_pkg::*;
#(
	parameter int BEEP_COUNT     = 4,
	parameter int CHECK_INTERVAL = 10
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire logic    button_pressed,
	input  wire cfg_t    cfg,
	output result_t      res
);

	phase_t      phase_q, phase_d;
	logic [11:0] timer_q, timer_d;
	logic [11:0] elapsed_q, elapsed_d;
	logic        short_q, short_d;
	logic [2:0]  beeps_q, beeps_d;
	logic [11:0] timer_inc;
	logic [11:0] elapsed_inc;
	logic [11:0] red_len;
	logic [2:0]  beeps_inc;

	always_comb begin
		res = '0;
		case (phase_q)
			PH_BEEP: begin
				res.car_red    = 1'b1;
				res.walk_green = 1'b1;
				res.tone_on    = (timer_q < {4'd0, cfg.beep_on_ticks});
				res.phase      = PHASE_CODE_BEEP;
			end
			PH_GREEN: begin
				res.car_green = 1'b1;
				res.walk_red  = 1'b1;
				res.phase     = PHASE_CODE_GREEN;
			end
			PH_HOLD: begin
				res.car_green = 1'b1;
				res.walk_red  = 1'b1;
				res.phase     = PHASE_CODE_HOLD;
			end
			PH_YELLOW: begin
				res.car_yellow = 1'b1;
				res.walk_red   = 1'b1;
				res.phase      = PHASE_CODE_YELLOW;
			end
			default: begin
				res.car_red    = 1'b1;
				res.walk_green = 1'b1;
				res.phase      = PHASE_CODE_RED;
			end
		endcase
	end

	assign timer_inc   = timer_q + 12'd1;
	assign elapsed_inc = (elapsed_q != TIMER_MAX) ? elapsed_q + 12'd1 : elapsed_q;
	assign red_len     = short_q ? cfg.red_short_ticks : cfg.red_long_ticks;
	assign beeps_inc   = beeps_q + 3'd1;

	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_inc;
		elapsed_d = elapsed_q;
		short_d   = short_q;
		beeps_d   = beeps_q;
		case (phase_q)
			PH_RED: begin
				if (timer_inc >= red_len) begin
					short_d = 1'b0;
					beeps_d = 3'd0;
					phase_d = PH_BEEP;
					timer_d = 12'd0;
				end
			end
			PH_BEEP: begin
				if (timer_inc >= {4'd0, cfg.beep_period_ticks}) begin
					timer_d = 12'd0;
					beeps_d = beeps_inc;
					if (beeps_inc >= 3'(BEEP_COUNT)) begin
						beeps_d   = 3'd0;
						elapsed_d = 12'd0;
						phase_d   = PH_GREEN;
					end
				end
			end
			PH_GREEN: begin
				elapsed_d = elapsed_inc;
				if (timer_inc >= 12'(CHECK_INTERVAL)) begin
					timer_d = 12'd0;
					if (button_pressed && (elapsed_inc < cfg.early_window_ticks)) begin
						short_d = 1'b1;
						phase_d = PH_HOLD;
					end else if ((elapsed_inc > cfg.green_max_ticks) ||
							(elapsed_inc == TIMER_MAX)) begin
						phase_d = PH_YELLOW;
					end
				end
			end
			PH_HOLD: begin
				if (timer_inc >= cfg.hold_ticks) begin
					phase_d = PH_YELLOW;
					timer_d = 12'd0;
				end
			end
			PH_YELLOW: begin
				if (timer_inc >= cfg.yellow_ticks) begin
					phase_d = PH_RED;
					timer_d = 12'd0;
				end
			end
			default: begin
				phase_d   = PH_RED;
				timer_d   = 12'd0;
				elapsed_d = 12'd0;
				beeps_d   = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_RED;
			timer_q   <= 12'd0;
			elapsed_q <= 12'd0;
			short_q   <= 1'b0;
			beeps_q   <= 3'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			elapsed_q <= elapsed_d;
			short_q   <= short_d;
			beeps_q   <= beeps_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ptl_checker.sv
// Port-level checker for the pedestrian traffic light controller, with its bind.
`default_nettype none

module ptl_checker
	import ptl_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       car_red,
	input wire logic       car_yellow,
	input wire logic       car_green,
	input wire logic       walk_red,
	input wire logic       walk_green,
	input wire logic       tone_on,
	input wire logic [2:0] phase
);

	// Exactly one traffic lamp is lit in every result beat.
	a_one_car_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({car_red, car_yellow, car_green}))
		else $error("traffic lamps not exclusive");

	// Pedestrians walk exactly when traffic sees red.
	a_walk_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (walk_green == car_red) && (walk_red == !car_red))
		else $error("pedestrian lamps disagree with traffic lamps");

	// The tone sounds only in the beep phase.
	a_tone_in_beep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tone_on) |-> (phase == PHASE_CODE_BEEP))
		else $error("tone outside beep phase");

	// Every accepted tick beat yields a result beat in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted beat produced no result");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(phase) && $stable(tone_on))
		else $error("stalled result changed");

endmodule

bind pedestrian_traffic_light_controller ptl_checker u_ptl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.car_red    (car_red),
	.car_yellow (car_yellow),
	.car_green  (car_green),
	.walk_red   (walk_red),
	.walk_green (walk_green),
	.tone_on    (tone_on),
	.phase      (phase)
);

`default_nettype wire

// File: tb/pedestrian_traffic_light_controller_test.sv
// Self-checking testbench for the pedestrian traffic light controller.
`default_nettype none

module pedestrian_traffic_light_controller_test;
	import ptl_pkg::*;

	localparam int BEEPS_PER_CROSSING = 4;
	localparam int CHECK_TICKS        = 10;
	localparam int CYCLE_LIMIT        = 1000000;
	localparam int HOLD_OFF_AT        = 300;
	localparam int HOLD_OFF_CYCLES    = 200;
	localparam int REG_COUNT          = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_RED_LONG;
	logic [11:0] cfg_data = 12'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        button_pressed = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        car_red;
	logic        car_yellow;
	logic        car_green;
	logic        walk_red;
	logic        walk_green;
	logic        tone_on;
	logic [2:0]  phase;

	// Mirror of the sequencer state and its timing registers.
	logic [2:0]  light_phase = PHASE_CODE_RED;
	logic [11:0] ticks_in_phase = 12'd0;
	logic [11:0] green_ticks = 12'd0;
	logic        red_cut = 1'b0;
	logic [2:0]  beeps_done = 3'd0;
	logic [11:0] timing_reg [REG_COUNT];
	logic [11:0] timing_plan [REG_COUNT];

	logic    button_ticks [$];
	result_t lamp_expect [$];
	result_t lamp_want;

	int gap_left = 0;
	int stall_left = 0;
	int beats_checked = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	bit long_hold_done = 1'b0;
	bit gap_mode = 1'b1;
	bit stall_mode = 1'b1;

	pedestrian_traffic_light_controller #(
		.BEEP_COUNT(BEEPS_PER_CROSSING),
		.CHECK_INTERVAL(CHECK_TICKS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_pressed(button_pressed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.car_red(car_red),
		.car_yellow(car_yellow),
		.car_green(car_green),
		.walk_red(walk_red),
		.walk_green(walk_green),
		.tone_on(tone_on),
		.phase(phase)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic result_t advance_lights(input logic btn);
		result_t r;
		logic    redish;
		logic    greenish;
		logic    amber;
		logic [11:0] red_len;
		redish   = (light_phase == PHASE_CODE_RED) || (light_phase == PHASE_CODE_BEEP);
		greenish = (light_phase == PHASE_CODE_GREEN) || (light_phase == PHASE_CODE_HOLD);
		amber    = (light_phase == PHASE_CODE_YELLOW);
		r.car_red    = redish;
		r.car_yellow = amber;
		r.car_green  = greenish;
		r.walk_red   = greenish | amber;
		r.walk_green = redish;
		r.tone_on    = (light_phase == PHASE_CODE_BEEP) && (ticks_in_phase < timing_reg[REG_BEEP_ON]);
		r.phase      = light_phase;

		ticks_in_phase = ticks_in_phase + 12'd1;
		case (light_phase)
			PHASE_CODE_RED: begin
				red_len = red_cut ? timing_reg[REG_RED_SHORT] : timing_reg[REG_RED_LONG];
				if (ticks_in_phase >= red_len) begin
					red_cut = 1'b0;
					beeps_done = 3'd0;
					light_phase = PHASE_CODE_BEEP;
					ticks_in_phase = 12'd0;
				end
			end
			PHASE_CODE_BEEP: begin
				if (ticks_in_phase >= timing_reg[REG_BEEP_PERIOD]) begin
					ticks_in_phase = 12'd0;
					beeps_done = beeps_done + 3'd1;
					if (beeps_done >= BEEPS_PER_CROSSING) begin
						beeps_done = 3'd0;
						green_ticks = 12'd0;
						light_phase = PHASE_CODE_GREEN;
					end
				end
			end
			PHASE_CODE_GREEN: begin
				if (green_ticks != TIMER_MAX)
					green_ticks = green_ticks + 12'd1;
				if (ticks_in_phase >= CHECK_TICKS) begin
					ticks_in_phase = 12'd0;
					if (btn && green_ticks < timing_reg[REG_EARLY_WINDOW]) begin
						red_cut = 1'b1;
						light_phase = PHASE_CODE_HOLD;
					end else if (green_ticks > timing_reg[REG_GREEN_MAX] ||
							green_ticks == TIMER_MAX) begin
						light_phase = PHASE_CODE_YELLOW;
					end
				end
			end
			PHASE_CODE_HOLD: begin
				if (ticks_in_phase >= timing_reg[REG_HOLD]) begin
					light_phase = PHASE_CODE_YELLOW;
					ticks_in_phase = 12'd0;
				end
			end
			default: begin
				if (ticks_in_phase >= timing_reg[REG_YELLOW]) begin
					light_phase = PHASE_CODE_RED;
					ticks_in_phase = 12'd0;
				end
			end
		endcase
		return r;
	endfunction

	function automatic int pick_idle(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (mismatch_count < 50)
			$display("mismatch at beat %0d: %s got %0d, expected %0d",
				beats_checked, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				lamp_expect.push_back(advance_lights(button_pressed));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (button_ticks.size() != 0) begin
					in_valid <= 1'b1;
					button_pressed <= button_ticks.pop_front();
					gap_left <= pick_idle(gap_mode);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (lamp_expect.size() == 0) begin
					flag_mismatch("beat with nothing expected", phase, 0);
				end else begin
					lamp_want = lamp_expect.pop_front();
					if (car_red !== lamp_want.car_red)
						flag_mismatch("car_red", car_red, lamp_want.car_red);
					if (car_yellow !== lamp_want.car_yellow)
						flag_mismatch("car_yellow", car_yellow, lamp_want.car_yellow);
					if (car_green !== lamp_want.car_green)
						flag_mismatch("car_green", car_green, lamp_want.car_green);
					if (walk_red !== lamp_want.walk_red)
						flag_mismatch("walk_red", walk_red, lamp_want.walk_red);
					if (walk_green !== lamp_want.walk_green)
						flag_mismatch("walk_green", walk_green, lamp_want.walk_green);
					if (tone_on !== lamp_want.tone_on)
						flag_mismatch("tone_on", tone_on, lamp_want.tone_on);
					if (phase !== lamp_want.phase)
						flag_mismatch("phase", phase, lamp_want.phase);
				end
				beats_checked <= beats_checked + 1;
			end
			if (!long_hold_done && beats_checked == HOLD_OFF_AT) begin
				long_hold_done <= 1'b1;
				stall_left <= HOLD_OFF_CYCLES;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (stall_mode && $urandom_range(0, 99) < 20) begin
				stall_left <= pick_idle(1'b1);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// The block is idle once no tick is queued or offered and every result has arrived.
	task automatic settle();
		while (button_ticks.size() != 0 || in_valid || lamp_expect.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_timing();
		for (int i = 0; i < REG_COUNT; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data <= timing_plan[i];
			timing_reg[i] = (i >= REG_BEEP_ON) ? (timing_plan[i] & 12'h0FF) : timing_plan[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_ticks(input int count, input int press_pct);
		gap_mode = ($urandom_range(0, 3) != 0);
		stall_mode = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < count; i++)
			button_ticks.push_back($urandom_range(0, 99) < press_pct);
		settle();
	endtask

	initial begin
		timing_reg[REG_RED_LONG]     = 12'd800;
		timing_reg[REG_RED_SHORT]    = 12'd200;
		timing_reg[REG_GREEN_MAX]    = 12'd800;
		timing_reg[REG_EARLY_WINDOW] = 12'd700;
		timing_reg[REG_HOLD]         = 12'd101;
		timing_reg[REG_YELLOW]       = 12'd60;
		timing_reg[REG_BEEP_ON]      = 12'd10;
		timing_reg[REG_BEEP_PERIOD]  = 12'd15;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults keep the lights in the long red phase.
		button_ticks.push_back(1'b0);
		button_ticks.push_back(1'b1);
		button_ticks.push_back(1'b0);
		button_ticks.push_back(1'b1);
		settle();

		// One short crossing: the press lands on the first green check while the
		// green time is already past its maximum, so the press must win and cut red.
		timing_plan[REG_RED_LONG]     = 12'd1;
		timing_plan[REG_RED_SHORT]    = 12'd1;
		timing_plan[REG_GREEN_MAX]    = 12'd5;
		timing_plan[REG_EARLY_WINDOW] = 12'd15;
		timing_plan[REG_HOLD]         = 12'd1;
		timing_plan[REG_YELLOW]       = 12'd1;
		timing_plan[REG_BEEP_ON]      = 12'd2;
		timing_plan[REG_BEEP_PERIOD]  = 12'd1;
		load_timing();
		for (int i = 0; i < 21; i++)
			button_ticks.push_back(i >= 3);
		settle();

		// Zero length everywhere: each beep period and every phase but green lasts one tick; green ends at its first check.
		for (int i = 0; i < REG_COUNT; i++)
			timing_plan[i] = 12'd0;
		load_timing();
		run_ticks(80, 50);

		for (int i = 0; i < REG_COUNT; i++)
			timing_plan[i] = 12'd1;
		load_timing();
		run_ticks(80, 50);

		for (int s = 0; s < 8; s++) begin
			timing_plan[REG_RED_LONG]     = 12'($urandom_range(1, 30));
			timing_plan[REG_RED_SHORT]    = 12'($urandom_range(0, 10));
			timing_plan[REG_GREEN_MAX]    = 12'($urandom_range(0, 60));
			timing_plan[REG_EARLY_WINDOW] = 12'($urandom_range(0, 60));
			timing_plan[REG_HOLD]         = 12'($urandom_range(0, 20));
			timing_plan[REG_YELLOW]       = 12'($urandom_range(0, 10));
			timing_plan[REG_BEEP_ON]      = {4'($urandom_range(0, 15)), 8'($urandom_range(0, 8))};
			timing_plan[REG_BEEP_PERIOD]  = {4'($urandom_range(0, 15)), 8'($urandom_range(0, 8))};
			load_timing();
			case ($urandom_range(0, 2))
				0: run_ticks(150, 5);
				1: run_ticks(150, 50);
				default: run_ticks(150, 95);
			endcase
		end

		for (int i = 0; i < REG_COUNT; i++)
			timing_plan[i] = TIMER_MAX;
		load_timing();
		run_ticks(300, 50);

		// No press can ever count, so green always runs until it passes its maximum.
		timing_plan[REG_RED_LONG]     = 12'd3;
		timing_plan[REG_RED_SHORT]    = 12'd2;
		timing_plan[REG_GREEN_MAX]    = 12'd100;
		timing_plan[REG_EARLY_WINDOW] = 12'd0;
		timing_plan[REG_HOLD]         = 12'd2;
		timing_plan[REG_YELLOW]       = 12'd2;
		timing_plan[REG_BEEP_ON]      = 12'd3;
		timing_plan[REG_BEEP_PERIOD]  = 12'd4;
		load_timing();
		run_ticks(165, 50);

		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && lamp_expect.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
